/* hw/rtl/rlfs_pkg.sv */
// ----------------------------------------------------------------------------
// rlfs_pkg
// Shared types, codes and helpers for the RGB LED flash sequencer.
// ----------------------------------------------------------------------------
package rlfs_pkg;

  // Tick counter width (supported range 8 to 32)
  localparam int TICK_COUNT_WIDTH = 16;

  // Field widths
  localparam int ACTION_WIDTH   = 3;
  localparam int COLOR_WIDTH    = 24;
  localparam int DURATION_WIDTH = 16;
  localparam int COUNT_WIDTH    = 8;
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = 16;

  // Flash count meaning "repeat until cancel"
  localparam logic [COUNT_WIDTH-1:0] COUNT_FOREVER = '0;

  // Largest value the tick counter holds
  localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = '1;

  // Width used to compare a duration against the counter range
  localparam int LOAD_WIDTH = (DURATION_WIDTH > TICK_COUNT_WIDTH) ?
                              DURATION_WIDTH : TICK_COUNT_WIDTH;

  typedef enum logic [ACTION_WIDTH-1:0] {
    ACT_TICK      = 3'd0,
    ACT_SET_COLOR = 3'd1,
    ACT_OFF       = 3'd2,
    ACT_FLASH     = 3'd3,
    ACT_CANCEL    = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_ON_TICKS    = 2'd0,
    CFG_OFF_TICKS   = 2'd1,
    CFG_FLASH_COUNT = 2'd2
  } cfg_index_t;

  // Request held in the input register
  typedef struct packed {
    logic                   valid;
    logic [ACTION_WIDTH-1:0] action;
    logic [COLOR_WIDTH-1:0]  color_rgb;
  } cmd_item_t;

  // Live configuration
  typedef struct packed {
    logic [DURATION_WIDTH-1:0] on_ticks;
    logic [DURATION_WIDTH-1:0] off_ticks;
    logic [COUNT_WIDTH-1:0]    flash_count;
  } cfg_regs_t;

  // Load a phase duration, saturating to the counter range
  function automatic logic [TICK_COUNT_WIDTH-1:0] load_ticks(
    input logic [DURATION_WIDTH-1:0] d
  );
    logic [LOAD_WIDTH-1:0] dw;
    dw = LOAD_WIDTH'(d);
    if (dw > LOAD_WIDTH'(TICK_MAX)) begin
      return TICK_MAX;
    end
    return TICK_COUNT_WIDTH'(dw);
  endfunction

endpackage

/* hw/rtl/rlfs_if.sv */
// ----------------------------------------------------------------------------
// rlfs_cmd_if / rlfs_rsp_if
// Valid/ready channels carrying sequencer requests and results.
// ----------------------------------------------------------------------------
interface rlfs_cmd_if;
  import rlfs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ACTION_WIDTH-1:0] action;
  logic [COLOR_WIDTH-1:0]  color_rgb;

  modport source (output valid, action, color_rgb, input ready);
  modport sink   (input valid, action, color_rgb, output ready);
endinterface

interface rlfs_rsp_if;
  import rlfs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [COLOR_WIDTH-1:0] led_color;
  logic                   led_update;
  logic                   busy_res;
  logic                   status;

  modport source (output valid, led_color, led_update, busy_res, status, input ready);
  modport sink   (input valid, led_color, led_update, busy_res, status, output ready);
endinterface

/* hw/rtl/rlfs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rlfs_cfg_regs
// Configuration register file: on_ticks, off_ticks and flash_count.
// ----------------------------------------------------------------------------
module rlfs_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rlfs_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [rlfs_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
  output rlfs_pkg::cfg_regs_t                 cfg
);
  import rlfs_pkg::*;

  // Write the addressed register; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ON_TICKS:    cfg.on_ticks    <= DURATION_WIDTH'(cfg_wdata);
        CFG_OFF_TICKS:   cfg.off_ticks   <= DURATION_WIDTH'(cfg_wdata);
        CFG_FLASH_COUNT: cfg.flash_count <= cfg_wdata[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/rlfs_in_reg.sv */
// ----------------------------------------------------------------------------
// rlfs_in_reg
// Input register: captures one request per cycle while cmd.ready is high.
// ----------------------------------------------------------------------------
module rlfs_in_reg (
  input  logic                clk,
  input  logic                rst,
  rlfs_cmd_if.sink            cmd,
  input  logic                advance,
  output rlfs_pkg::cmd_item_t item
);
  import rlfs_pkg::*;

  // Accept when empty or when the held request moves on this cycle
  assign cmd.ready = !item.valid || advance;

  // Hold the valid flag and capture the payload on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (cmd.ready) begin
      item.valid <= cmd.valid;
      if (cmd.valid) begin
        item.action    <= cmd.action;
        item.color_rgb <= cmd.color_rgb;
      end
    end
  end

endmodule

/* hw/rtl/rlfs_engine.sv */
// ----------------------------------------------------------------------------
// rlfs_engine
// Sequencer state, single-pass next-state logic and the result register.
// ----------------------------------------------------------------------------
module rlfs_engine (
  input  logic                clk,
  input  logic                rst,
  input  rlfs_pkg::cmd_item_t item,
  input  rlfs_pkg::cfg_regs_t cfg,
  output logic                advance,
  rlfs_rsp_if.source          rsp
);
  import rlfs_pkg::*;

  logic [COLOR_WIDTH-1:0]      shown_color, shown_color_next;
  logic [COLOR_WIDTH-1:0]      flash_color, flash_color_next;
  logic                        sequence_active, sequence_active_next;
  logic                        phase_lit, phase_lit_next;
  logic [TICK_COUNT_WIDTH-1:0] ticks_left, ticks_left_next;
  logic [COUNT_WIDTH-1:0]      pulses_done, pulses_done_next;
  logic [COUNT_WIDTH-1:0]      pulses_inc;
  logic                        update;
  logic                        refused;

  // Move the held request when the result slot is free or draining
  assign advance = item.valid && (!rsp.valid || rsp.ready);

  assign pulses_inc = pulses_done + COUNT_WIDTH'(1);

  // Next state for the held request
  always_comb begin
    shown_color_next     = shown_color;
    flash_color_next     = flash_color;
    sequence_active_next = sequence_active;
    phase_lit_next       = phase_lit;
    ticks_left_next      = ticks_left;
    pulses_done_next     = pulses_done;
    update               = 1'b0;
    refused              = 1'b0;

    case (item.action)
      ACT_TICK: begin
        if (sequence_active) begin
          if (ticks_left > TICK_COUNT_WIDTH'(1)) begin
            ticks_left_next = ticks_left - TICK_COUNT_WIDTH'(1);
          end else if (phase_lit) begin
            // lit phase over: go dark, then pause or finish
            update           = 1'b1;
            shown_color_next = '0;
            phase_lit_next   = 1'b0;
            if (cfg.flash_count == COUNT_FOREVER || pulses_inc < cfg.flash_count) begin
              pulses_done_next = pulses_inc;
              ticks_left_next  = load_ticks(cfg.off_ticks);
            end else begin
              sequence_active_next = 1'b0;
              pulses_done_next     = '0;
              ticks_left_next      = '0;
            end
          end else begin
            // dark phase over: relight
            update           = 1'b1;
            phase_lit_next   = 1'b1;
            shown_color_next = flash_color;
            ticks_left_next  = load_ticks(cfg.on_ticks);
          end
        end
      end
      ACT_SET_COLOR: begin
        shown_color_next = item.color_rgb;
        update           = 1'b1;
      end
      ACT_OFF: begin
        if (sequence_active) begin
          refused = 1'b1;
        end else begin
          shown_color_next = '0;
          update           = 1'b1;
        end
      end
      ACT_FLASH: begin
        if (sequence_active) begin
          refused = 1'b1;
        end else begin
          flash_color_next = item.color_rgb;
          shown_color_next = item.color_rgb;
          update           = 1'b1;
          if (cfg.on_ticks != '0) begin
            sequence_active_next = 1'b1;
            phase_lit_next       = 1'b1;
            pulses_done_next     = '0;
            ticks_left_next      = load_ticks(cfg.on_ticks);
          end
        end
      end
      ACT_CANCEL: begin
        sequence_active_next = 1'b0;
        phase_lit_next       = 1'b0;
        ticks_left_next      = '0;
        pulses_done_next     = '0;
        shown_color_next     = '0;
        update               = 1'b1;
      end
      default: ;
    endcase
  end

  // Advance the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      shown_color     <= '0;
      flash_color     <= '0;
      sequence_active <= 1'b0;
      phase_lit       <= 1'b0;
      ticks_left      <= '0;
      pulses_done     <= '0;
    end else if (advance) begin
      shown_color     <= shown_color_next;
      flash_color     <= flash_color_next;
      sequence_active <= sequence_active_next;
      phase_lit       <= phase_lit_next;
      ticks_left      <= ticks_left_next;
      pulses_done     <= pulses_done_next;
    end
  end

  // Hold the result valid until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.led_color  <= shown_color_next;
      rsp.led_update <= update;
      rsp.busy_res   <= sequence_active_next;
      rsp.status     <= refused;
    end
  end

endmodule

/* hw/rtl/rgb_led_flash_sequencer.sv */
// ----------------------------------------------------------------------------
// rgb_led_flash_sequencer
// RGB indicator controller: set color, off, timed flash sequences, cancel.
//
//   channel  dir  handshake     payload
//   cmd      in   valid/ready   action[2:0], color_rgb[23:0]
//   rsp      out  valid/ready   led_color[23:0], led_update, busy_res, status
//   cfg      in   cfg_we        cfg_index[1:0], cfg_wdata[15:0]
//
// One request per clock while the result register is free or draining; a
// request accepted into the input register moves on when the result register
// is free or draining, and its result is then loaded there and offered.
// The state update is a single pass of the engine logic between the two.
// A stalled result holds; the input register keeps taking a request as long
// as the result register is free or drains in the same cycle.
// Reset (rst, synchronous) empties both registers and clears the state.
// ----------------------------------------------------------------------------
module rgb_led_flash_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  rlfs_cmd_if.sink                            cmd,
  rlfs_rsp_if.source                          rsp,
  input  logic                                cfg_we,
  input  logic [rlfs_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [rlfs_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata
);
  import rlfs_pkg::*;

  cfg_regs_t cfg;
  cmd_item_t item;
  logic      advance;

  rlfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rlfs_in_reg u_in (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .advance (advance),
    .item    (item)
  );

  rlfs_engine u_eng (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .cfg     (cfg),
    .advance (advance),
    .rsp     (rsp)
  );

endmodule

/* hw/rtl/rlfs_checker.sv */
// ----------------------------------------------------------------------------
// rlfs_checker
// Port-level checks on the sequencer result channel.
// ----------------------------------------------------------------------------
module rlfs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic [rlfs_pkg::COLOR_WIDTH-1:0]  led_color,
  input logic                              led_update,
  input logic                              busy_res,
  input logic                              status
);
  import rlfs_pkg::*;

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // A refused request never rewrites the LED
  a_refuse_no_update: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> !led_update)
    else $error("refused request updated the LED");

  // Refusal only happens while a sequence is running
  a_refuse_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> busy_res)
    else $error("refusal reported while idle");

  // Stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(led_color) &&
    $stable(led_update) && $stable(busy_res) && $stable(status))
    else $error("stalled result changed");

endmodule

bind rgb_led_flash_sequencer rlfs_checker u_rlfs_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .led_color  (rsp.led_color),
  .led_update (rsp.led_update),
  .busy_res   (rsp.busy_res),
  .status     (rsp.status)
);

/* verif/rgb_led_flash_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// rgb_led_flash_sequencer_tb
// Self-checking bench for the RGB LED flash sequencer. A queue of requests
// feeds a valid/ready driver. A monitor checks each result field by field
// against a cycle-free model of the LED state that runs at request
// acceptance. Phases vary the flash timing registers and the idle and stall
// rates on both channels. One phase holds off the result side long enough
// to back up the request channel.
// ----------------------------------------------------------------------------
module rgb_led_flash_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlfs_pkg::*;

  localparam int                      CYCLE_LIMIT  = 400000;
  localparam int                      LONG_HOLD    = 300;
  localparam int                      REPORT_LIMIT = 200;
  localparam int                      SPARE_WIDTH  = CFG_DATA_WIDTH - COUNT_WIDTH;
  localparam logic [ACTION_WIDTH-1:0] ACT_LAST     = '1;

  typedef struct packed {
    logic [ACTION_WIDTH-1:0] action;
    logic [COLOR_WIDTH-1:0]  color_rgb;
  } led_req_t;

  typedef struct packed {
    logic [COLOR_WIDTH-1:0] led_color;
    logic                   led_update;
    logic                   busy_res;
    logic                   status;
  } led_result_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata;

  rlfs_cmd_if cmd_ch ();
  rlfs_rsp_if rsp_ch ();

  rgb_led_flash_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Request backlog and results still owed by the block
  led_req_t    led_cmd_q[$];
  led_result_t led_result_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  bit hold_flip;

  // Model copy of the configuration
  logic [DURATION_WIDTH-1:0] on_dur;
  logic [DURATION_WIDTH-1:0] off_dur;
  logic [COUNT_WIDTH-1:0]    pulse_target;

  // Model copy of the LED state
  logic [COLOR_WIDTH-1:0]      shown_rgb;
  logic [COLOR_WIDTH-1:0]      flash_rgb;
  logic                        seq_running;
  logic                        lit_phase;
  logic [TICK_COUNT_WIDTH-1:0] ticks_remaining;
  logic [COUNT_WIDTH-1:0]      pulse_tally;

  // Saturate a phase duration to the tick counter range
  function automatic logic [TICK_COUNT_WIDTH-1:0] counter_load(
    input logic [DURATION_WIDTH-1:0] d
  );
    longint unsigned dl;
    longint unsigned top;
    dl  = d;
    top = (64'd1 << TICK_COUNT_WIDTH) - 1;
    if (dl > top) return '1;
    return TICK_COUNT_WIDTH'(dl);
  endfunction

  // Advance the LED model by one request and return what the block reports
  task automatic step_led_model(input led_req_t req, output led_result_t res);
    logic updated;
    logic refused;
    updated = 1'b0;
    refused = 1'b0;
    case (req.action)
      ACT_TICK: begin
        if (seq_running) begin
          if (ticks_remaining > 1) begin
            ticks_remaining = ticks_remaining - TICK_COUNT_WIDTH'(1);
          end else if (lit_phase) begin
            shown_rgb   = '0;
            lit_phase   = 1'b0;
            pulse_tally = pulse_tally + COUNT_WIDTH'(1);
            updated     = 1'b1;
            if (pulse_target == COUNT_FOREVER || pulse_tally < pulse_target) begin
              ticks_remaining = counter_load(off_dur);
            end else begin
              seq_running     = 1'b0;
              pulse_tally     = '0;
              ticks_remaining = '0;
            end
          end else begin
            lit_phase       = 1'b1;
            shown_rgb       = flash_rgb;
            ticks_remaining = counter_load(on_dur);
            updated         = 1'b1;
          end
        end
      end
      ACT_SET_COLOR: begin
        shown_rgb = req.color_rgb;
        updated   = 1'b1;
      end
      ACT_OFF: begin
        if (seq_running) begin
          refused = 1'b1;
        end else begin
          shown_rgb = '0;
          updated   = 1'b1;
        end
      end
      ACT_FLASH: begin
        if (seq_running) begin
          refused = 1'b1;
        end else begin
          flash_rgb = req.color_rgb;
          shown_rgb = req.color_rgb;
          updated   = 1'b1;
          if (on_dur != 0) begin
            seq_running     = 1'b1;
            lit_phase       = 1'b1;
            pulse_tally     = '0;
            ticks_remaining = counter_load(on_dur);
          end
        end
      end
      ACT_CANCEL: begin
        seq_running     = 1'b0;
        lit_phase       = 1'b0;
        ticks_remaining = '0;
        pulse_tally     = '0;
        shown_rgb       = '0;
        updated         = 1'b1;
      end
      default: begin
      end
    endcase
    res.led_color  = shown_rgb;
    res.led_update = updated;
    res.busy_res   = seq_running;
    res.status     = refused;
  endtask

  // Report one field that disagrees
  task automatic check_field(input string name, input logic [COLOR_WIDTH-1:0] exp_v,
                             input logic [COLOR_WIDTH-1:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Give up on a hung run
  int cycle_count;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL rgb_led_flash_sequencer");
      $finish;
    end
  end

  // Request driver: predict on acceptance, then offer the next request
  always @(posedge clk) begin
    led_req_t    nxt;
    led_result_t res;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        step_led_model({cmd_ch.action, cmd_ch.color_rgb}, res);
        led_result_q.push_back(res);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (led_cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = led_cmd_q.pop_front();
          cmd_ch.valid     <= 1'b1;
          cmd_ch.action    <= nxt.action;
          cmd_ch.color_rgb <= nxt.color_rgb;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check against the oldest prediction, drive ready
  bit hold_seen;
  int hold_left;
  always @(posedge clk) begin
    led_result_t exp_r;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (led_result_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none actual %h", $realtime,
                   rsp_ch.led_color);
        end else begin
          exp_r = led_result_q.pop_front();
          check_field("led_color", exp_r.led_color, rsp_ch.led_color);
          check_field("led_update", COLOR_WIDTH'(exp_r.led_update),
                      COLOR_WIDTH'(rsp_ch.led_update));
          check_field("busy_res", COLOR_WIDTH'(exp_r.busy_res),
                      COLOR_WIDTH'(rsp_ch.busy_res));
          check_field("status", COLOR_WIDTH'(exp_r.status), COLOR_WIDTH'(rsp_ch.status));
        end
      end
      if (hold_seen != hold_flip) begin
        hold_seen = hold_flip;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic queue_req(input logic [ACTION_WIDTH-1:0] act,
                           input logic [COLOR_WIDTH-1:0] rgb);
    led_cmd_q.push_back({act, rgb});
  endtask

  // Random traffic: mostly tick bursts, plus flashes, other requests and undefined codes
  task automatic queue_random(input int n);
    int added;
    int pick;
    int burst;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        burst = $urandom_range(1, 6);
        repeat (burst) queue_req(ACT_TICK, COLOR_WIDTH'($urandom));
        added += burst;
      end else begin
        if (pick < 63)      queue_req(ACT_FLASH, COLOR_WIDTH'($urandom));
        else if (pick < 71) queue_req(ACT_SET_COLOR, COLOR_WIDTH'($urandom));
        else if (pick < 78) queue_req(ACT_OFF, COLOR_WIDTH'($urandom));
        else if (pick < 85) queue_req(ACT_CANCEL, COLOR_WIDTH'($urandom));
        else if (pick < 91) queue_req(ACTION_WIDTH'($urandom_range(ACT_CANCEL + 1, ACT_LAST)),
                                      COLOR_WIDTH'($urandom));
        else                queue_req(ACT_TICK, COLOR_WIDTH'($urandom));
        added++;
      end
    end
  endtask

  // Write all three timing registers back to back
  task automatic load_config(input logic [DURATION_WIDTH-1:0] on_v,
                             input logic [DURATION_WIDTH-1:0] off_v,
                             input logic [COUNT_WIDTH-1:0] cnt_v);
    logic [SPARE_WIDTH-1:0] spare;
    spare = SPARE_WIDTH'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ON_TICKS;
    cfg_wdata <= on_v;
    @(posedge clk);
    cfg_index <= CFG_OFF_TICKS;
    cfg_wdata <= off_v;
    @(posedge clk);
    cfg_index <= CFG_FLASH_COUNT;
    cfg_wdata <= {spare, cnt_v};
    @(posedge clk);
    cfg_we <= 1'b0;
    on_dur       = on_v;
    off_dur      = off_v;
    pulse_target = cnt_v;
  endtask

  // Hold until every request went in and every result came back
  task automatic wait_drained();
    do @(negedge clk);
    while (led_cmd_q.size() != 0 || cmd_ch.valid || led_result_q.size() != 0);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct,
                           input logic [DURATION_WIDTH-1:0] on_v,
                           input logic [DURATION_WIDTH-1:0] off_v,
                           input logic [COUNT_WIDTH-1:0] cnt_v, input int n);
    load_config(on_v, off_v, cnt_v);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(n);
    wait_drained();
  endtask

  // Stimulus
  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = CFG_ON_TICKS;
    cfg_wdata        = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.action    = ACT_TICK;
    cmd_ch.color_rgb = '0;
    rsp_ch.ready     = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    mismatch_count   = 0;
    hold_flip        = 1'b0;
    on_dur           = '0;
    off_dur          = '0;
    pulse_target     = '0;
    shown_rgb        = '0;
    flash_rgb        = '0;
    seq_running      = 1'b0;
    lit_phase        = 1'b0;
    ticks_remaining  = '0;
    pulse_tally      = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset timing: idle tick, color extremes, flash without a sequence,
    // off, cancel while idle, undefined codes
    @(negedge clk);
    queue_req(ACT_TICK, 24'hFFFFFF);
    queue_req(ACT_SET_COLOR, 24'hFFFFFF);
    queue_req(ACT_SET_COLOR, 24'h000000);
    queue_req(ACT_FLASH, 24'h5A5A5A);
    queue_req(ACT_OFF, 24'hA5A5A5);
    queue_req(ACT_CANCEL, 24'h000000);
    for (int c = ACT_CANCEL + 1; c <= ACT_LAST; c++)
      queue_req(ACTION_WIDTH'(c), COLOR_WIDTH'($urandom));
    queue_req(ACT_TICK, 24'h000000);
    wait_drained();

    // Two pulses with a zero-length dark phase; busy refusals; set color
    // overwritten by the sequence
    load_config(16'd2, 16'd0, 8'd2);
    @(negedge clk);
    queue_req(ACT_FLASH, 24'hC3C3C3);
    queue_req(ACT_OFF, 24'h000000);
    queue_req(ACT_FLASH, 24'h123456);
    queue_req(ACT_TICK, 24'h000000);
    queue_req(ACT_SET_COLOR, 24'h0F0F0F);
    repeat (5) queue_req(ACT_TICK, 24'h000000);
    wait_drained();

    // Continuous flashing stopped by cancel, then cancel while idle
    load_config(16'd1, 16'd1, COUNT_FOREVER);
    @(negedge clk);
    queue_req(ACT_FLASH, 24'hFFFFFF);
    repeat (4) queue_req(ACT_TICK, 24'h000000);
    queue_req(ACT_CANCEL, 24'h000000);
    queue_req(ACT_CANCEL, 24'hFFFFFF);
    wait_drained();

    // Random phases over idle and stall patterns
    run_phase(0, 0, 16'd3, 16'd2, 8'd2, 120);
    run_phase(55, 0, 16'd1, 16'd0, COUNT_FOREVER, 120);
    run_phase(0, 55, 16'hFFFF, 16'hFFFF, 8'hFF, 80);
    run_phase(19, 19, DURATION_WIDTH'($urandom_range(1, 6)),
              DURATION_WIDTH'($urandom_range(0, 6)), COUNT_WIDTH'($urandom_range(0, 5)), 140);

    // Back up the request channel behind a long result stall
    load_config(16'd2, 16'd1, 8'd3);
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_flip      = ~hold_flip;
    queue_random(100);
    wait_drained();

    run_phase(0, 0, 16'd0, DURATION_WIDTH'($urandom), COUNT_WIDTH'($urandom), 60);
    run_phase(19, 19, DURATION_WIDTH'($urandom), DURATION_WIDTH'($urandom),
              COUNT_WIDTH'($urandom), 60);

    // Let the pipeline settle, then report
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS rgb_led_flash_sequencer");
    end else begin
      $display("FAIL rgb_led_flash_sequencer");
    end
    $finish;
  end

endmodule

/* rgb_led_flash_sequencer.f */
hw/rtl/rlfs_pkg.sv
hw/rtl/rlfs_if.sv
hw/rtl/rlfs_cfg_regs.sv
hw/rtl/rlfs_in_reg.sv
hw/rtl/rlfs_engine.sv
hw/rtl/rgb_led_flash_sequencer.sv
hw/rtl/rlfs_checker.sv
verif/rgb_led_flash_sequencer_tb.sv
